FILE: hw/rtl/nlm_pkg.sv
// ----------------------------------------------------------------------------
// nlm_pkg: shared types and codes for the node liveness monitor
// Item and result layouts, action and result-kind codes, and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package nlm_pkg;

    localparam int ACT_W  = 3;
    localparam int ID_W   = 8;
    localparam int VAL_W  = 8;
    localparam int KIND_W = 4;
    localparam int CNT_W  = 4;

    // Input actions (codes 5..7 are unused and ignored)
    localparam logic [ACT_W-1:0] ACT_REGISTER = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REPORT   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PONG     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TICK     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_COMMAND  = 3'd4;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ACK      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_PING     = 4'd1;
    localparam logic [KIND_W-1:0] KIND_CMD      = 4'd2;
    localparam logic [KIND_W-1:0] KIND_ONLINE   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_OFFLINE  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_STATE    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_NOTFOUND = 4'd6;
    localparam logic [KIND_W-1:0] KIND_DONE     = 4'd7;
    localparam logic [KIND_W-1:0] KIND_BAD      = 4'd8;

    localparam logic [CNT_W-1:0] MISS_LIMIT_RST = 4'd3;
    localparam logic [CNT_W-1:0] CNT_MAX        = 4'hF;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ID_W-1:0]  node_id;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   node_id_out;
        logic [ID_W-1:0]   seq;
        logic [VAL_W-1:0]  payload;
        logic              last;
    } t_out_item;

    // Controller -> datapath
    typedef struct packed {
        logic load_item;    // capture the accepted item
        logic do_item;      // execute a non-tick item, emit its first result if it has one
        logic do_online;    // emit the online notice after a register
        logic sweep_start;  // clear the slot counter
        logic sweep_read;   // read the missed count of the current slot
        logic sweep_step;   // evaluate current slot, advance
        logic sweep_done;   // emit the sweep done marker
    } t_ctl_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic             out_free;
        logic [ACT_W-1:0] action;
        logic             id_bad;
        logic             slot_online;
        logic             slot_last;
    } t_dp_sts;

endpackage

FILE: hw/rtl/nlm_ctrl.sv
// ----------------------------------------------------------------------------
// nlm_ctrl: sequencing state machine
// Dispatches each accepted item and walks the node slots on a keepalive tick.
// ----------------------------------------------------------------------------
module nlm_ctrl
    import nlm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_sts  i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ITEM   = 6'b000010,
        ST_ONLINE = 6'b000100,
        ST_RD     = 6'b001000,
        ST_EV     = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_ITEM;
                end
            end
            ST_ITEM: begin
                if (i_sts.action == ACT_TICK) begin
                    o_cmd.sweep_start = 1'b1;
                    n_state           = ST_RD;
                end else if (i_sts.action > ACT_COMMAND) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.do_item = 1'b1;
                    n_state = (i_sts.action == ACT_REGISTER && !i_sts.id_bad) ?
                              ST_ONLINE : ST_IDLE;
                end
            end
            ST_ONLINE: begin
                if (i_sts.out_free) begin
                    o_cmd.do_online = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_RD: begin
                o_cmd.sweep_read = 1'b1;
                n_state          = ST_EV;
            end
            ST_EV: begin
                // offline slots are skipped without touching the output
                if (!i_sts.slot_online || i_sts.out_free) begin
                    o_cmd.sweep_step = 1'b1;
                    n_state          = i_sts.slot_last ? ST_DONE : ST_RD;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.sweep_done = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/nlm_datapath.sv
// ----------------------------------------------------------------------------
// nlm_datapath: node tables, sequence counter and result register
// Known/online flags in flops, missed-ping counts in a small RAM that is
// only meaningful while the node is online (cleared on every go-online).
// ----------------------------------------------------------------------------
module nlm_datapath
    import nlm_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl_cmd         i_cmd,
    output t_dp_sts          o_sts,
    input  t_in_item         i_in_item,
    input  logic             i_cfg_valid,
    input  logic [CNT_W-1:0] i_cfg_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    localparam int SLOT_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [ID_W-1:0]   MAX_ID    = ID_W'(MAX_NODES);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_NODES - 1);

    t_in_item               r_item;
    logic [MAX_NODES-1:0]   r_known;
    logic [MAX_NODES-1:0]   r_online;
    logic [MAX_NODES-1:0]   n_known;
    logic [MAX_NODES-1:0]   n_online;
    logic [SLOT_W-1:0]      r_slot;
    logic [CNT_W-1:0]       r_miss_rd;
    logic [CNT_W-1:0]       r_miss_mem [MAX_NODES];
    logic [ID_W-1:0]        r_seq;
    logic [CNT_W-1:0]       r_miss_limit;
    t_out_item              r_out;
    t_out_item              n_out;
    logic                   r_out_valid;

    logic                   emit;
    logic                   seq_adv;
    logic                   mem_we;
    logic [SLOT_W-1:0]      mem_wa;
    logic [CNT_W-1:0]       mem_wd;
    logic [SLOT_W-1:0]      item_slot;
    logic                   id_bad;
    logic                   item_known;
    logic                   slot_online;
    logic                   at_limit;
    logic [ID_W-1:0]        slot_id;

    assign item_slot   = SLOT_W'(r_item.node_id - ID_W'(1));
    assign id_bad      = (r_item.node_id == '0) || (r_item.node_id > MAX_ID);
    assign item_known  = r_known[item_slot];
    assign slot_online = r_online[r_slot];
    assign at_limit    = (r_miss_rd >= r_miss_limit);
    assign slot_id     = ID_W'(r_slot) + ID_W'(1);

    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.action      = r_item.action;
    assign o_sts.id_bad      = id_bad;
    assign o_sts.slot_online = slot_online;
    assign o_sts.slot_last   = (r_slot == LAST_SLOT);

    always_comb begin
        emit     = 1'b0;
        seq_adv  = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = item_slot;
        mem_wd   = '0;
        n_known  = r_known;
        n_online = r_online;
        n_out    = '0;
        n_out.node_id_out = r_item.node_id;

        if (i_cmd.do_item) begin
            if (id_bad) begin
                emit       = 1'b1;
                n_out.kind = KIND_BAD;
                n_out.last = 1'b1;
            end else begin
                case (r_item.action)
                    ACT_REGISTER: begin
                        n_known[item_slot]  = 1'b1;
                        n_online[item_slot] = 1'b1;
                        mem_we      = 1'b1;
                        emit        = 1'b1;
                        seq_adv     = 1'b1;
                        n_out.kind  = KIND_ACK;
                        n_out.seq   = r_seq;
                    end
                    ACT_REPORT: begin
                        mem_we        = 1'b1;
                        emit          = 1'b1;
                        n_out.kind    = KIND_STATE;
                        n_out.payload = r_item.value;
                        n_out.last    = 1'b1;
                    end
                    ACT_PONG: begin
                        mem_we = 1'b1;
                        if (item_known) begin
                            n_online[item_slot] = 1'b1;
                        end
                    end
                    ACT_COMMAND: begin
                        emit       = 1'b1;
                        n_out.last = 1'b1;
                        if (item_known) begin
                            seq_adv       = 1'b1;
                            n_out.kind    = KIND_CMD;
                            n_out.seq     = r_seq;
                            n_out.payload = r_item.value;
                        end else begin
                            n_out.kind = KIND_NOTFOUND;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (i_cmd.do_online) begin
            emit       = 1'b1;
            n_out.kind = KIND_ONLINE;
            n_out.last = 1'b1;
        end

        if (i_cmd.sweep_step && slot_online) begin
            emit              = 1'b1;
            mem_we            = 1'b1;
            mem_wa            = r_slot;
            n_out.node_id_out = slot_id;
            if (at_limit) begin
                n_online[r_slot] = 1'b0;
                n_out.kind       = KIND_OFFLINE;
            end else begin
                // saturating missed-ping count
                mem_wd     = (r_miss_rd == CNT_MAX) ? r_miss_rd : r_miss_rd + CNT_W'(1);
                seq_adv    = 1'b1;
                n_out.kind = KIND_PING;
                n_out.seq  = r_seq;
            end
        end

        if (i_cmd.sweep_done) begin
            emit              = 1'b1;
            n_out.kind        = KIND_DONE;
            n_out.node_id_out = '0;
            n_out.last        = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known      <= '0;
            r_online     <= '0;
            r_seq        <= '0;
            r_miss_limit <= MISS_LIMIT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_known  <= n_known;
            r_online <= n_online;
            if (seq_adv) begin
                r_seq <= r_seq + ID_W'(1);
            end
            if (i_cfg_valid) begin
                r_miss_limit <= i_cfg_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        if (emit) begin
            r_out <= n_out;
        end
        if (i_cmd.sweep_start) begin
            r_slot <= '0;
        end else if (i_cmd.sweep_step) begin
            r_slot <= r_slot + SLOT_W'(1);
        end
    end

    // missed-count RAM, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_miss_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.sweep_read) begin
            r_miss_rd <= r_miss_mem[r_slot];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: hw/rtl/node_liveness_monitor_unit.sv
// ----------------------------------------------------------------------------
// node_liveness_monitor_unit: per-node heartbeat / keepalive tracker
// Tracks known, online and missed-ping state per node slot and emits
// ack, ping and cmd notices stamped with an 8-bit sequence number, and status notices.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (miss limit)
//
// Flow: one item at a time. Register, report, pong and command items are
//   executed in the item state; a register with a valid id then emits its online
//   notice. A keepalive tick walks every node slot (registered read of the
//   missed-count RAM, then evaluate/write back) and then emits the done marker.
// Reset: synchronous, active low; clears the node flags, the sequence counter
//   and the output valid flag and sets the miss limit to 3. No clearing pass.
// Stalls: results sit in a single output register; the sequencer waits on it
//   before any non-tick item of a valid action (a pong too, though it places
//   nothing), the online notice, each online-slot sweep result and done marker.
// The cfg port is always ready, not gated: write the miss limit only while idle.
//
module node_liveness_monitor_unit
    import nlm_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // item transfers
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    // result transfers
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    // miss limit register
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    t_ctl_cmd ctl_cmd;
    t_dp_sts  dp_sts;

    // register write takes effect at the transfer edge, never stalls
    assign o_cfg_ready = 1'b1;

    // Sequencer: dispatch of items and the slot walk of a tick
    nlm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (ctl_cmd)
    );

    // Node tables, sequence counter and the result register
    nlm_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .o_sts       (dp_sts),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: hw/rtl/nlm_checker.sv
// ----------------------------------------------------------------------------
// nlm_checker: port-level assertions for the liveness monitor
// Watches the result channel for handshake and result-format rules.
// ----------------------------------------------------------------------------
module nlm_checker
    import nlm_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    localparam logic [ID_W-1:0] MAX_ID = ID_W'(MAX_NODES);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // sweep marker closes the item and names no node
    a_done_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_DONE |->
            o_out_item.last && o_out_item.node_id_out == '0)
        else $error("bad sweep done marker");

    // sweep results concern a real slot and never end the item
    a_sweep_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind == KIND_PING || o_out_item.kind == KIND_OFFLINE) |->
            !o_out_item.last && o_out_item.node_id_out != '0 &&
            o_out_item.node_id_out <= MAX_ID)
        else $error("sweep result out of range");

    // only ack, ping and cmd carry a sequence number
    a_seq_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.seq != '0 |->
            o_out_item.kind == KIND_ACK || o_out_item.kind == KIND_PING ||
            o_out_item.kind == KIND_CMD)
        else $error("sequence number on unstamped result");

    // ack is always followed by its online notice
    a_ack_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_item.kind == KIND_ACK |=>
            !o_out_valid || o_out_item.kind == KIND_ONLINE)
        else $error("ack not followed by online notice");

endmodule

bind node_liveness_monitor_unit nlm_checker #(
    .MAX_NODES (MAX_NODES)
) u_nlm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
